// File: rtl/grid_cube_sphere_classifier_core_defines.svh
// Assertion macros shared by the grid cell classifier RTL.
// No dependencies; the assertions compile away when SYNTHESIS is defined.
`ifndef GRID_CUBE_SPHERE_CLASSIFIER_CORE_DEFINES_SVH
`define GRID_CUBE_SPHERE_CLASSIFIER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check an implication or property at every rising edge out of reset
`define GCSC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gcsc: property check failed");
// Check that a condition never occurs out of reset
`define GCSC_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("gcsc: forbidden condition seen");
`else
`define GCSC_ASSERT(lbl, clk, rst, prop)
`define GCSC_NEVER(lbl, clk, rst, cond)
`endif
`endif

// File: rtl/gcsc_pkg.sv
// Shared types and fixed constants of the grid cell classifier.
// No dependencies; the modules and gcsc_in_if refer to it by scoped names.
package gcsc_pkg;

  // Fixed field widths
  localparam int IDX_W      = 12;
  localparam int AXES_ALL   = 10;
  localparam int DIM_W      = 4;
  localparam int CPA_W      = 13;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_DIM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS = 2'd1;
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;
  localparam logic [CPA_W-1:0] CPA_RESET = 13'd2662;

  // Queue between classify and count sides
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_INSIDE   = 2'd0,
    KIND_OUTSIDE  = 2'd1,
    KIND_STRADDLE = 2'd2
  } kind_t;

  // One classified cell waiting to be counted
  typedef struct packed {
    kind_t kind;
    logic  clear;
  } cls_t;

  typedef logic [AXES_ALL-1:0][IDX_W-1:0] idx_vec_t;

endpackage

// File: rtl/gcsc_in_if.sv
// Input channel: one grid cell per beat, valid/ready handshake.
// Depends on gcsc_pkg for the index width.
interface gcsc_in_if;
  logic                      valid;
  logic                      ready;
  logic [gcsc_pkg::IDX_W-1:0] index_0;
  logic [gcsc_pkg::IDX_W-1:0] index_1;
  logic [gcsc_pkg::IDX_W-1:0] index_2;
  logic [gcsc_pkg::IDX_W-1:0] index_3;
  logic [gcsc_pkg::IDX_W-1:0] index_4;
  logic [gcsc_pkg::IDX_W-1:0] index_5;
  logic [gcsc_pkg::IDX_W-1:0] index_6;
  logic [gcsc_pkg::IDX_W-1:0] index_7;
  logic [gcsc_pkg::IDX_W-1:0] index_8;
  logic [gcsc_pkg::IDX_W-1:0] index_9;
  logic                      clear_counts;

  modport source (
    output valid, index_0, index_1, index_2, index_3, index_4,
           index_5, index_6, index_7, index_8, index_9, clear_counts,
    input  ready
  );
  modport sink (
    input  valid, index_0, index_1, index_2, index_3, index_4,
           index_5, index_6, index_7, index_8, index_9, clear_counts,
    output ready
  );
endinterface

// File: rtl/gcsc_out_if.sv
// Output channel: one classification result and the running tallies per beat.
// Standalone; the tally width is set at instantiation.
interface gcsc_out_if #(
  parameter int TALLY_BITS = 48
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            cell_kind;
  logic [TALLY_BITS-1:0] inside_total;
  logic [TALLY_BITS-1:0] outside_total;
  logic [TALLY_BITS-1:0] processed_total;

  modport source (
    output valid, cell_kind, inside_total, outside_total, processed_total,
    input  ready
  );
  modport sink (
    input  valid, cell_kind, inside_total, outside_total, processed_total,
    output ready
  );
endinterface

// File: rtl/grid_cube_sphere_classifier_core.sv
// Top level of the grid cell versus unit sphere classifier.
// Depends on gcsc_pkg, gcsc_in_if, gcsc_out_if, gcsc_front, gcsc_fifo, gcsc_back.
//
// Takes one grid cell per beat and returns one beat with its class (inside,
// outside or straddling the unit sphere) and the saturating inside, outside
// and processed tallies after that cell. A new cell is accepted every cycle
// while results drain; each cell passes three classify stages (offsets,
// squares, group sums), then the queue and the tally register. The classify
// side issues cells against a credit of eight queue entries, so a stalled
// output lets up to eight cells stay in flight before the input deasserts
// ready. Configuration registers are written through cfg_we/cfg_index/cfg_data
// by the user only while no cell is in flight; the block does not enforce it.
module grid_cube_sphere_classifier_core #(
  parameter int MAX_AXES           = 10,
  parameter int MAX_CELLS_PER_AXIS = 4096,
  parameter int TALLY_BITS         = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gcsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcsc_pkg::CFG_DATA_W-1:0] cfg_data,
  gcsc_in_if.sink                         cells,
  gcsc_out_if.source                      results
);

  logic [gcsc_pkg::DIM_W-1:0] dim_reg;
  logic [gcsc_pkg::CPA_W-1:0] cells_reg;
  gcsc_pkg::idx_vec_t         idx_vec;
  logic                       push;
  gcsc_pkg::cls_t             push_data;
  logic                       pop;
  logic                       not_empty;
  gcsc_pkg::cls_t             head;

  // Register writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_reg   <= gcsc_pkg::DIM_RESET;
      cells_reg <= gcsc_pkg::CPA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcsc_pkg::REG_DIM:   dim_reg   <= cfg_data[gcsc_pkg::DIM_W-1:0];
        gcsc_pkg::REG_CELLS: cells_reg <= cfg_data[gcsc_pkg::CPA_W-1:0];
        default: ;
      endcase
    end
  end

  // Gather the per-axis indices
  assign idx_vec[0] = cells.index_0;
  assign idx_vec[1] = cells.index_1;
  assign idx_vec[2] = cells.index_2;
  assign idx_vec[3] = cells.index_3;
  assign idx_vec[4] = cells.index_4;
  assign idx_vec[5] = cells.index_5;
  assign idx_vec[6] = cells.index_6;
  assign idx_vec[7] = cells.index_7;
  assign idx_vec[8] = cells.index_8;
  assign idx_vec[9] = cells.index_9;

  gcsc_front #(
    .MAX_AXES           (MAX_AXES),
    .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cells.valid),
    .in_ready  (cells.ready),
    .idx       (idx_vec),
    .clear_in  (cells.clear_counts),
    .dim       (dim_reg),
    .cells     (cells_reg),
    .pop       (pop),
    .push      (push),
    .push_data (push_data)
  );

  gcsc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  gcsc_back #(
    .TALLY_BITS (TALLY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ent_valid (not_empty),
    .ent       (head),
    .pop       (pop),
    .res       (results)
  );

endmodule

// File: rtl/gcsc_front.sv
// Classify side: accepts cells, squares vertex offsets per axis, sums and
// compares against K*K. Depends on gcsc_pkg and the assertion header.
`include "grid_cube_sphere_classifier_core_defines.svh"
module gcsc_front #(
  parameter int MAX_AXES           = 10,
  parameter int MAX_CELLS_PER_AXIS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gcsc_pkg::idx_vec_t            idx,
  input  logic                          clear_in,
  input  logic [gcsc_pkg::DIM_W-1:0]    dim,
  input  logic [gcsc_pkg::CPA_W-1:0]    cells,
  input  logic                          pop,
  output logic                          push,
  output gcsc_pkg::cls_t                push_data
);

  localparam int KW   = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int CMPW = (KW > gcsc_pkg::CPA_W) ? KW : gcsc_pkg::CPA_W;
  localparam int BW   = (gcsc_pkg::IDX_W + 1 > KW) ? gcsc_pkg::IDX_W + 1 : KW;
  localparam int SW   = BW + 1;
  localparam int SQW  = 2 * SW;
  localparam int NGRP = (MAX_AXES + 3) / 4;
  localparam int GSW  = SQW + 2;
  localparam int SUMW = GSW + $clog2(NGRP + 1);
  localparam int LIMW = 2 * KW;
  localparam int CW   = gcsc_pkg::FIFO_CNT_W;

  logic [KW-1:0]                 k_eff;
  logic [gcsc_pkg::DIM_W-1:0]    d_eff;
  logic [LIMW-1:0]               limit;
  logic [CW-1:0]                 in_flight;
  logic                          accept;

  logic signed [SW-1:0]          c_s    [MAX_AXES];
  logic [SW-1:0]                 mag    [MAX_AXES];
  logic [SW-1:0]                 far_n  [MAX_AXES];
  logic [SW-1:0]                 near_n [MAX_AXES];

  logic                          vld_a, vld_b, vld_c;
  logic                          clr_a, clr_b, clr_c;
  logic [SW-1:0]                 far_a  [MAX_AXES];
  logic [SW-1:0]                 near_a [MAX_AXES];
  logic [SQW-1:0]                sq_far [MAX_AXES];
  logic [SQW-1:0]                sq_near[MAX_AXES];
  logic [GSW-1:0]                gf_n   [NGRP];
  logic [GSW-1:0]                gn_n   [NGRP];
  logic [GSW-1:0]                gf     [NGRP];
  logic [GSW-1:0]                gn     [NGRP];
  logic [SUMW-1:0]               far_sum, near_sum;

  // Clamp the configured dimension and grid size into the supported range
  always_comb begin
    if (cells == '0) begin
      k_eff = KW'(1);
    end else if (CMPW'(cells) > CMPW'(MAX_CELLS_PER_AXIS)) begin
      k_eff = KW'(MAX_CELLS_PER_AXIS);
    end else begin
      k_eff = KW'(cells);
    end
    if (dim == '0) begin
      d_eff = gcsc_pkg::DIM_W'(1);
    end else if (dim > gcsc_pkg::DIM_W'(MAX_AXES)) begin
      d_eff = gcsc_pkg::DIM_W'(MAX_AXES);
    end else begin
      d_eff = dim;
    end
  end

  // Hold K*K; lag is harmless if the user changes config only while idle (not enforced)
  always_ff @(posedge clk) begin
    limit <= LIMW'(k_eff) * LIMW'(k_eff);
  end

  // Credit: cells in the pipe plus cells in the queue never exceed its depth
  assign accept   = in_valid && in_ready;
  assign in_ready = (in_flight < CW'(gcsc_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + CW'(accept) - CW'(pop);
    end
  end

  // Per axis: center offset c = 2i+1-K, far and near vertex magnitudes
  always_comb begin
    for (int a = 0; a < MAX_AXES; a++) begin
      c_s[a] = $signed(SW'({idx[a], 1'b1})) - $signed(SW'(k_eff));
      mag[a] = c_s[a][SW-1] ? SW'(-c_s[a]) : SW'(c_s[a]);
      if (gcsc_pkg::DIM_W'(a) < d_eff) begin
        far_n[a]  = mag[a] + SW'(1);
        near_n[a] = (mag[a] == '0) ? SW'(1) : mag[a] - SW'(1);
      end else begin
        far_n[a]  = '0;
        near_n[a] = '0;
      end
    end
  end

  // Stage A: latch magnitudes of the accepted cell
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else begin
      vld_a <= accept;
    end
    clr_a <= clear_in;
    for (int a = 0; a < MAX_AXES; a++) begin
      far_a[a]  <= far_n[a];
      near_a[a] <= near_n[a];
    end
  end

  // Stage B: square each magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else begin
      vld_b <= vld_a;
    end
    clr_b <= clr_a;
    for (int a = 0; a < MAX_AXES; a++) begin
      sq_far[a]  <= SQW'(far_a[a]) * SQW'(far_a[a]);
      sq_near[a] <= SQW'(near_a[a]) * SQW'(near_a[a]);
    end
  end

  // Group the squares four axes at a time
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      gf_n[g] = '0;
      gn_n[g] = '0;
    end
    for (int a = 0; a < MAX_AXES; a++) begin
      gf_n[a >> 2] = gf_n[a >> 2] + GSW'(sq_far[a]);
      gn_n[a >> 2] = gn_n[a >> 2] + GSW'(sq_near[a]);
    end
  end

  // Stage C: latch group sums
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c <= 1'b0;
    end else begin
      vld_c <= vld_b;
    end
    clr_c <= clr_b;
    for (int g = 0; g < NGRP; g++) begin
      gf[g] <= gf_n[g];
      gn[g] <= gn_n[g];
    end
  end

  // Finish the sums and classify against K*K
  always_comb begin
    far_sum  = '0;
    near_sum = '0;
    for (int g = 0; g < NGRP; g++) begin
      far_sum  = far_sum + SUMW'(gf[g]);
      near_sum = near_sum + SUMW'(gn[g]);
    end
    if (far_sum <= SUMW'(limit)) begin
      push_data.kind = gcsc_pkg::KIND_INSIDE;
    end else if (near_sum > SUMW'(limit)) begin
      push_data.kind = gcsc_pkg::KIND_OUTSIDE;
    end else begin
      push_data.kind = gcsc_pkg::KIND_STRADDLE;
    end
    push_data.clear = clr_c;
  end

  assign push = vld_c;

  `GCSC_ASSERT(a_credit_bound, clk, rst, in_flight <= CW'(gcsc_pkg::FIFO_DEPTH))

endmodule

// File: rtl/gcsc_fifo.sv
// Short queue of classified cells between the classify and count sides.
// Depends on gcsc_pkg and the assertion header.
`include "grid_cube_sphere_classifier_core_defines.svh"
module gcsc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gcsc_pkg::cls_t push_data,
  input  logic           pop,
  output logic           not_empty,
  output gcsc_pkg::cls_t head
);

  localparam int AW = gcsc_pkg::FIFO_AW;
  localparam int CW = gcsc_pkg::FIFO_CNT_W;

  gcsc_pkg::cls_t slots [gcsc_pkg::FIFO_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  `GCSC_NEVER(a_fifo_overflow, clk, rst, push && (count == CW'(gcsc_pkg::FIFO_DEPTH)))
  `GCSC_NEVER(a_fifo_underflow, clk, rst, pop && (count == '0))

endmodule

// File: rtl/gcsc_back.sv
// Count side: pops classified cells, updates saturating tallies and holds
// the result beat. Depends on gcsc_pkg, gcsc_out_if and the assertion header.
`include "grid_cube_sphere_classifier_core_defines.svh"
module gcsc_back #(
  parameter int TALLY_BITS = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           ent_valid,
  input  gcsc_pkg::cls_t ent,
  output logic           pop,
  gcsc_out_if.source     res
);

  logic                  out_valid;
  gcsc_pkg::kind_t       kind;
  logic [TALLY_BITS-1:0] inside_tally;
  logic [TALLY_BITS-1:0] outside_tally;
  logic [TALLY_BITS-1:0] processed_tally;
  logic [TALLY_BITS-1:0] in_base, out_base, proc_base;
  logic [TALLY_BITS-1:0] inside_next, outside_next, processed_next;

  // Take the next cell when the result slot is free or being drained
  assign pop = ent_valid && (!out_valid || res.ready);

  // Clear first if asked, then bump with saturation at all ones
  always_comb begin
    in_base   = ent.clear ? '0 : inside_tally;
    out_base  = ent.clear ? '0 : outside_tally;
    proc_base = ent.clear ? '0 : processed_tally;
    processed_next = (&proc_base) ? proc_base : proc_base + TALLY_BITS'(1);
    inside_next    = in_base;
    outside_next   = out_base;
    if (ent.kind == gcsc_pkg::KIND_INSIDE) begin
      inside_next = (&in_base) ? in_base : in_base + TALLY_BITS'(1);
    end
    if (ent.kind == gcsc_pkg::KIND_OUTSIDE) begin
      outside_next = (&out_base) ? out_base : out_base + TALLY_BITS'(1);
    end
  end

  // Tallies double as the result payload; hold them while the beat stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      inside_tally    <= '0;
      outside_tally   <= '0;
      processed_tally <= '0;
    end else if (pop) begin
      out_valid       <= 1'b1;
      inside_tally    <= inside_next;
      outside_tally   <= outside_next;
      processed_tally <= processed_next;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= ent.kind;
    end
  end

  assign res.valid           = out_valid;
  assign res.cell_kind       = kind;
  assign res.inside_total    = inside_tally;
  assign res.outside_total   = outside_tally;
  assign res.processed_total = processed_tally;

  `GCSC_ASSERT(a_inside_le_proc, clk, rst, out_valid |-> (inside_tally <= processed_tally))
  `GCSC_ASSERT(a_outside_le_proc, clk, rst, out_valid |-> (outside_tally <= processed_tally))

endmodule
